// ===== hdl/shtp_pkg.sv =====
// Shared types and constants for the symbol hash table probe.
`timescale 1ns / 1ps

package shtp_pkg;

  localparam int unsigned NAME_CHARS_DEF  = 6;
  localparam int unsigned TABLE_SLOTS_DEF = 256;

  localparam int unsigned SYM_NAME_W = 48;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_IDX_W = 8;
  localparam int unsigned HASH_W     = 16;
  localparam int unsigned RECIP_SH   = 32;

  localparam logic [7:0] CHAR_LOW7 = 8'h7f;

  localparam logic [STATUS_W-1:0] STATUS_FOUND  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic                  req_type;
    logic [SYM_NAME_W-1:0] symbol_name;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_index;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_PROBE
  } state_e;

endpackage

// ===== hdl/shtp_home_calc.sv =====
// Home slot unit: byte-pair hash, then modulo slot count by reciprocal multiply.
`timescale 1ns / 1ps

module shtp_home_calc #(
  parameter int unsigned NAME_CHARS  = shtp_pkg::NAME_CHARS_DEF,
  parameter int unsigned TABLE_SLOTS = shtp_pkg::TABLE_SLOTS_DEF,
  localparam int unsigned NW = NAME_CHARS * 8,
  localparam int unsigned IW = $clog2(TABLE_SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] name_i,
  output logic          done_o,
  output logic [IW-1:0] home_o
);

  localparam int unsigned HW    = shtp_pkg::HASH_W;
  localparam int unsigned RW    = IW + 1;
  localparam int unsigned PW    = HW + shtp_pkg::RECIP_SH;
  localparam int unsigned PAIRS = NAME_CHARS / 2;
  // floor(2^32 / N): quotient estimate is at most one short
  localparam logic [31:0] RECIP = 32'((64'd1 << shtp_pkg::RECIP_SH) / TABLE_SLOTS);
  localparam logic [RW-1:0] SLOTS_R = RW'(TABLE_SLOTS);

  logic [2:0]    stg_q, stg_d;
  logic [HW-1:0] sum_q, sum_d;
  logic [HW-1:0] quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [PW-1:0] prod;
  logic [31:0]   qn;

  // 16-bit wrapping sum of byte pairs, first byte high
  always_comb begin
    sum_d = '0;
    for (int p = 0; p < PAIRS; p++) begin
      sum_d = sum_d + name_i[NW-1-16*p -: 16];
    end
  end

  assign prod  = PW'(sum_q) * PW'(RECIP);
  assign quo_d = prod[PW-1 -: HW];
  assign qn    = 32'(quo_q) * 32'(TABLE_SLOTS);
  assign rem_d = RW'(32'(sum_q) - qn);
  assign stg_d = {stg_q[1:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= stg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_d;
    end
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = stg_q[2];
  assign home_o = (rem_q >= SLOTS_R) ? IW'(rem_q - SLOTS_R) : IW'(rem_q);

  a_done_after_start : assert property (
    @(posedge clk_i) disable iff (!rst_ni) start_i |-> ##3 done_o
  ) else $error("home slot not ready three cycles after start");

  a_home_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> (32'(home_o) < 32'(TABLE_SLOTS))
  ) else $error("home slot beyond table");

  a_rem_corrected : assert property (
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> (rem_q < 2 * SLOTS_R)
  ) else $error("remainder needs more than one correction");

endmodule

// ===== hdl/symbol_hash_table_probe.sv =====
// Top level: open-addressing symbol table with linear probing.
`timescale 1ns / 1ps

// Symbol hash table probe.
// Input channel (in_valid_i / in_stall_o / in_req_i) carries one request per
// transaction: a lookup, or an add that stores the name if it is absent.
// Output channel (out_valid_o / out_stall_i / out_rsp_o) returns exactly one
// response per request: found, absent/inserted or table full, plus the slot.
// Sequencing: one request is in flight at a time. After the accepting edge the
// home slot unit registers the hash sum, the reciprocal multiply and the
// remainder in turn, then each probed slot takes one read of the table RAM.
// The slots probed number 1 for a hit on the home slot, up to TABLE_SLOTS
// when the table is full.
// The response lands in an output register; the next request is accepted
// while that response still waits. If the response register is still held
// by a stalled receiver, the last probe holds until it frees up.
// Reset: the table RAM is cleared by a sweep over all TABLE_SLOTS slots, one slot
// per cycle; in_stall_o stays high during the sweep.
// Table full: reports the home slot and writes nothing, also for an add.

module symbol_hash_table_probe #(
  parameter int unsigned NAME_CHARS  = shtp_pkg::NAME_CHARS_DEF,
  parameter int unsigned TABLE_SLOTS = shtp_pkg::TABLE_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  shtp_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output shtp_pkg::rsp_t out_rsp_o
);

  localparam int unsigned NW = NAME_CHARS * 8;
  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);
  localparam logic [NW-1:0] LOW7_MASK = {NAME_CHARS{shtp_pkg::CHAR_LOW7}};

  shtp_pkg::state_e state_q, state_d;

  // Table RAM, one read and one write port, registered read
  logic [NW-1:0] mem [TABLE_SLOTS];
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [NW-1:0] mem_wd;
  logic [IW-1:0] rd_addr;
  logic [NW-1:0] rd_data_q;

  logic [IW-1:0] clr_cnt_q, clr_cnt_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [IW-1:0] home_q, home_d;
  logic [NW-1:0] name_q;
  logic          add_q;
  logic [NW-1:0] in_name;

  logic          hc_start;
  logic          hc_done;
  logic [IW-1:0] hc_home;

  logic          out_valid_q, out_valid_d;
  shtp_pkg::rsp_t rsp_q, rsp_d;

  logic          in_accept;
  logic          out_free;
  logic          slot_empty;
  logic          slot_match;
  logic [IW-1:0] next_pos;
  logic          wrap_full;
  logic          finish;
  logic          deliver;

  assign in_name   = NW'(in_req_i.symbol_name);
  assign in_accept = in_valid_i && !in_stall_o;
  assign hc_start  = in_accept;

  shtp_home_calc #(
    .NAME_CHARS  (NAME_CHARS),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_home (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hc_start),
    .name_i  (in_name),
    .done_o  (hc_done),
    .home_o  (hc_home)
  );

  // Probe evaluation on the slot read last cycle
  assign slot_empty = (rd_data_q[NW-1 -: 8] & shtp_pkg::CHAR_LOW7) == 8'h00;
  assign slot_match = ((rd_data_q ^ name_q) & LOW7_MASK) == '0;
  assign next_pos   = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;
  assign wrap_full  = (next_pos == home_q);
  assign finish     = slot_empty || slot_match || wrap_full;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign deliver    = (state_q == shtp_pkg::ST_PROBE) && finish && out_free;

  // Next state
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      shtp_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_SLOT) begin
          state_d = shtp_pkg::ST_IDLE;
        end
      end
      shtp_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = shtp_pkg::ST_HOME;
        end
      end
      shtp_pkg::ST_HOME: begin
        if (hc_done) begin
          state_d = shtp_pkg::ST_PROBE;
        end
      end
      shtp_pkg::ST_PROBE: begin
        if (deliver) begin
          state_d = shtp_pkg::ST_IDLE;
        end
      end
      default: state_d = shtp_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    in_stall_o  = 1'b1;
    rd_addr     = pos_q;
    pos_d       = pos_q;
    home_d      = home_q;
    mem_we      = 1'b0;
    mem_wa      = pos_q;
    mem_wd      = name_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      shtp_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_q;
        mem_wd = '0;
      end
      shtp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      shtp_pkg::ST_HOME: begin
        if (hc_done) begin
          rd_addr = hc_home;
          pos_d   = hc_home;
          home_d  = hc_home;
        end
      end
      shtp_pkg::ST_PROBE: begin
        if (!finish) begin
          rd_addr = next_pos;
          pos_d   = next_pos;
        end else if (deliver) begin
          out_valid_d = 1'b1;
          if (slot_empty) begin
            rsp_d.status     = shtp_pkg::STATUS_ABSENT;
            rsp_d.slot_index = shtp_pkg::SLOT_IDX_W'(pos_q);
            mem_we           = add_q;
          end else if (slot_match) begin
            rsp_d.status     = shtp_pkg::STATUS_FOUND;
            rsp_d.slot_index = shtp_pkg::SLOT_IDX_W'(pos_q);
          end else begin
            rsp_d.status     = shtp_pkg::STATUS_FULL;
            rsp_d.slot_index = shtp_pkg::SLOT_IDX_W'(home_q);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shtp_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      name_q <= in_name;
      add_q  <= in_req_i.req_type;
    end
    pos_q  <= pos_d;
    home_q <= home_d;
    rsp_q  <= rsp_d;
  end

  // Write-back happens only on the last probe of a request; the next
  // request reads only after the idle state and the home slot unit, so no forwarding.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_we_state : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      mem_we |-> (state_q == shtp_pkg::ST_CLEAR || state_q == shtp_pkg::ST_PROBE)
  ) else $error("table written outside clear sweep or probe");

  a_rsp_from_probe : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> ($past(state_q) == shtp_pkg::ST_PROBE)
  ) else $error("response raised outside probe");

  a_done_in_home : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      hc_done |-> (state_q == shtp_pkg::ST_HOME)
  ) else $error("home slot ready while not waiting for it");

  a_pos_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == shtp_pkg::ST_PROBE) |-> (32'(pos_q) < 32'(TABLE_SLOTS))
  ) else $error("probe position beyond table");

endmodule
